// File: hdl/exponential_bucket_histogram_defines.svh
// assertion macros shared by the histogram rtl
`ifndef EXPONENTIAL_BUCKET_HISTOGRAM_DEFINES_SVH
`define EXPONENTIAL_BUCKET_HISTOGRAM_DEFINES_SVH

`ifndef SYNTHESIS
// antecedent implies consequent in the same cycle
`define EBH_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// antecedent implies consequent in the next cycle
`define EBH_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define EBH_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg)
`define EBH_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

// File: hdl/ebh_pkg.sv
package ebh_pkg;

    localparam int REQ_W       = 2;
    localparam int SAMPLE_W    = 32;
    localparam int IDX_OUT_W   = 6;
    localparam int COUNT_OUT_W = 32;
    localparam int BOUND_W     = 48;
    localparam int SUM_W       = 64;
    localparam int FIRST_W     = 32;
    localparam int GROWTH_W    = 16;
    localparam int USE_W       = 7;
    localparam int WALK_W      = 9;
    localparam int PROD_W      = BOUND_W + GROWTH_W;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 32;
    localparam int FRAC_BITS   = 8;

    localparam logic [BOUND_W-1:0] BOUND_MAX = '1;

    // request codes on the input channel
    localparam logic [REQ_W-1:0] REQ_SUBMIT = 2'd0;
    localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_READ   = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_BOUND = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GROWTH      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BUCKETS     = 2'd2;

    localparam logic [FIRST_W-1:0]  RST_FIRST_BOUND = 32'd1;
    localparam logic [GROWTH_W-1:0] RST_GROWTH      = 16'd512;
    localparam logic [USE_W-1:0]    RST_BUCKETS     = 7'd64;

    typedef enum logic [1:0] {
        OP_SUBMIT,
        OP_CLEAR,
        OP_READ,
        OP_NOP
    } t_op;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_READ,
        ST_FIN
    } t_state;

    typedef struct packed {
        logic [FIRST_W-1:0]  first_bound;
        logic [GROWTH_W-1:0] growth;
        logic [USE_W-1:0]    buckets;
    } t_cfg;

    typedef struct packed {
        t_op                  op;
        logic [SAMPLE_W-1:0]  sample;
        logic [IDX_OUT_W-1:0] index;
    } t_item;

endpackage

// File: hdl/ebh_front.sv
`include "exponential_bucket_histogram_defines.svh"

module ebh_front #(
    parameter int SAMPLE_BITS = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [ebh_pkg::REQ_W-1:0]     i_req_type,
    input  logic [ebh_pkg::SAMPLE_W-1:0]  i_sample,
    input  logic [ebh_pkg::IDX_OUT_W-1:0] i_bucket_index,
    output logic                          o_item_vld,
    output ebh_pkg::t_item                o_item,
    input  logic                          i_pop
);

    localparam int SW = (SAMPLE_BITS < ebh_pkg::SAMPLE_W) ? SAMPLE_BITS : ebh_pkg::SAMPLE_W;
    localparam logic [ebh_pkg::SAMPLE_W-1:0] SMASK = {ebh_pkg::SAMPLE_W{1'b1}} >>
                                                    (ebh_pkg::SAMPLE_W - SW);
    localparam int Q_DEPTH = 2;

    ebh_pkg::t_item r_q [Q_DEPTH];
    logic           r_wp;
    logic           r_rp;
    logic [1:0]     r_cnt;
    logic [1:0]     n_cnt;
    ebh_pkg::t_item n_item;
    logic           push;

    // classify the request
    always_comb begin
        n_item.sample = i_sample & SMASK;
        n_item.index  = i_bucket_index;
        case (i_req_type)
            ebh_pkg::REQ_SUBMIT: n_item.op = ebh_pkg::OP_SUBMIT;
            ebh_pkg::REQ_CLEAR:  n_item.op = ebh_pkg::OP_CLEAR;
            ebh_pkg::REQ_READ:   n_item.op = ebh_pkg::OP_READ;
            default:             n_item.op = ebh_pkg::OP_NOP;
        endcase
    end

    assign o_stall    = (r_cnt == 2'(Q_DEPTH));
    assign push       = i_valid && !o_stall;
    assign o_item_vld = (r_cnt != 2'd0);
    assign o_item     = r_q[r_rp];

    always_comb begin
        n_cnt = r_cnt;
        if (push && !i_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (!push && i_pop) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= n_item;
        end
    end

    `EBH_ASSERT_NOW(a_pop_nonempty, i_clk, i_rst_n, i_pop, r_cnt != 2'd0, "pop from empty queue")

endmodule

// File: hdl/ebh_back.sv
`include "exponential_bucket_histogram_defines.svh"

module ebh_back #(
    parameter int NUM_BUCKETS = 64,
    parameter int SAMPLE_BITS = 32,
    parameter int COUNT_BITS  = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  ebh_pkg::t_cfg                   i_cfg,
    input  logic                            i_item_vld,
    input  ebh_pkg::t_item                  i_item,
    output logic                            o_pop,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [ebh_pkg::COUNT_OUT_W-1:0] o_bucket_count,
    output logic [ebh_pkg::BOUND_W-1:0]     o_bucket_bound,
    output logic [ebh_pkg::IDX_OUT_W-1:0]   o_chosen_bucket,
    output logic [ebh_pkg::SAMPLE_W-1:0]    o_min_sample,
    output logic [ebh_pkg::SAMPLE_W-1:0]    o_max_sample,
    output logic [ebh_pkg::SUM_W-1:0]       o_sample_sum,
    output logic [ebh_pkg::COUNT_OUT_W-1:0] o_sample_count,
    output logic                            o_has_samples
);

    localparam int IDX_W = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
    localparam int SW    = (SAMPLE_BITS < ebh_pkg::SAMPLE_W) ? SAMPLE_BITS : ebh_pkg::SAMPLE_W;
    localparam logic [ebh_pkg::SAMPLE_W-1:0] SMASK = {ebh_pkg::SAMPLE_W{1'b1}} >>
                                                    (ebh_pkg::SAMPLE_W - SW);
    localparam logic [ebh_pkg::WALK_W-1:0] NB_W = ebh_pkg::WALK_W'(NUM_BUCKETS);
    localparam logic [COUNT_BITS-1:0]      CMAX = '1;
    localparam int FRAC_BITS_W = ebh_pkg::FRAC_BITS;

    ebh_pkg::t_state r_state, n_state;
    ebh_pkg::t_op    r_op, n_op;
    logic [ebh_pkg::SAMPLE_W-1:0] r_sample, n_sample;
    logic [ebh_pkg::WALK_W-1:0]   r_tgt, n_tgt;
    logic [ebh_pkg::WALK_W-1:0]   r_n, n_n;
    logic [ebh_pkg::WALK_W-1:0]   r_i, n_i;
    logic [ebh_pkg::BOUND_W-1:0]  r_b, n_b;
    logic                         r_hit, n_hit;

    // bucket count memory and per-entry valid bits
    logic [COUNT_BITS-1:0]  r_mem [NUM_BUCKETS];
    logic [NUM_BUCKETS-1:0] r_vld;
    logic [COUNT_BITS-1:0]  r_rd_data;
    logic                   r_rd_vld;
    logic [IDX_W-1:0]       addr;
    logic                   rd_en;
    logic                   mem_we;
    logic                   clr;

    // running statistics
    logic [ebh_pkg::SAMPLE_W-1:0] r_min, n_min;
    logic [ebh_pkg::SAMPLE_W-1:0] r_max, n_max;
    logic [ebh_pkg::SUM_W-1:0]    r_sum, n_sum;
    logic [COUNT_BITS-1:0]        r_total, n_total;

    // output register
    logic                            r_out_vld, n_out_vld;
    logic [ebh_pkg::COUNT_OUT_W-1:0] r_o_count, n_o_count;
    logic [ebh_pkg::BOUND_W-1:0]     r_o_bound, n_o_bound;
    logic [ebh_pkg::IDX_OUT_W-1:0]   r_o_chosen, n_o_chosen;
    logic [ebh_pkg::SAMPLE_W-1:0]    r_o_min, n_o_min;
    logic [ebh_pkg::SAMPLE_W-1:0]    r_o_max, n_o_max;
    logic [ebh_pkg::SUM_W-1:0]       r_o_sum, n_o_sum;
    logic [ebh_pkg::COUNT_OUT_W-1:0] r_o_total, n_o_total;
    logic                            r_o_has, n_o_has;

    logic [ebh_pkg::WALK_W-1:0]       used_raw;
    logic [ebh_pkg::WALK_W-1:0]       used;
    logic [ebh_pkg::WALK_W-1:0]       item_tgt;
    logic                             item_in;
    logic [ebh_pkg::WALK_W-1:0]       i_inc;
    logic [ebh_pkg::PROD_W-1:0]       prod;
    logic [ebh_pkg::PROD_W-FRAC_BITS_W-1:0] prod_sh;
    logic [ebh_pkg::BOUND_W-1:0]      next_b;
    logic                             walk_done;
    logic                             out_free;

    logic [COUNT_BITS-1:0]        cur;
    logic [COUNT_BITS-1:0]        inc;
    logic [COUNT_BITS-1:0]        f_cnt;
    logic [ebh_pkg::BOUND_W-1:0]  f_bnd;
    logic [ebh_pkg::IDX_OUT_W-1:0] f_chosen;
    logic [ebh_pkg::SAMPLE_W-1:0] f_min;
    logic [ebh_pkg::SAMPLE_W-1:0] f_max;
    logic [ebh_pkg::SUM_W-1:0]    f_sum;
    logic [COUNT_BITS-1:0]        f_total;
    logic                         f_has;

    // buckets in use clamped to 1..NUM_BUCKETS
    assign used_raw = ebh_pkg::WALK_W'(i_cfg.buckets);
    assign used     = (used_raw == '0) ? ebh_pkg::WALK_W'(1) :
                      (used_raw > NB_W) ? NB_W : used_raw;
    assign item_tgt = ebh_pkg::WALK_W'(i_item.index);
    assign item_in  = (item_tgt < used);
    assign i_inc    = r_i + ebh_pkg::WALK_W'(1);

    // next bound: one 48x16 multiply per walk step, then saturate
    assign prod    = ebh_pkg::PROD_W'(r_b) * ebh_pkg::PROD_W'(i_cfg.growth);
    assign prod_sh = prod[ebh_pkg::PROD_W-1:FRAC_BITS_W];
    assign next_b  = (prod_sh > (ebh_pkg::PROD_W - FRAC_BITS_W)'(ebh_pkg::BOUND_MAX)) ?
                     ebh_pkg::BOUND_MAX : prod_sh[ebh_pkg::BOUND_W-1:0];

    always_comb begin
        if (r_op == ebh_pkg::OP_SUBMIT) begin
            walk_done = (ebh_pkg::BOUND_W'(r_sample) < r_b) || (i_inc == r_n);
        end else begin
            walk_done = (r_i == r_tgt);
        end
    end

    assign addr     = r_i[IDX_W-1:0];
    assign out_free = !r_out_vld || !i_stall;

    // result and statistics update for the item in the finish step
    always_comb begin
        cur      = r_rd_vld ? r_rd_data : '0;
        inc      = (cur == CMAX) ? cur : cur + COUNT_BITS'(1);
        f_cnt    = '0;
        f_bnd    = '0;
        f_chosen = '0;
        f_min    = r_min;
        f_max    = r_max;
        f_sum    = r_sum;
        f_total  = r_total;
        case (r_op)
            ebh_pkg::OP_SUBMIT: begin
                f_cnt    = inc;
                f_bnd    = r_b;
                f_chosen = ebh_pkg::IDX_OUT_W'(r_i);
                f_total  = (r_total == CMAX) ? r_total : r_total + COUNT_BITS'(1);
                f_sum    = r_sum + ebh_pkg::SUM_W'(r_sample);
                f_min    = (r_sample < r_min) ? r_sample : r_min;
                f_max    = (r_sample > r_max) ? r_sample : r_max;
            end
            ebh_pkg::OP_CLEAR: begin
                f_min   = SMASK;
                f_max   = '0;
                f_sum   = '0;
                f_total = '0;
            end
            ebh_pkg::OP_READ: begin
                f_cnt = r_hit ? cur : '0;
                f_bnd = r_hit ? r_b : '0;
            end
            default: begin
                f_cnt = '0;
            end
        endcase
        f_has = (f_total != '0);
    end

    // sequencer
    always_comb begin
        n_state    = r_state;
        n_op       = r_op;
        n_sample   = r_sample;
        n_tgt      = r_tgt;
        n_n        = r_n;
        n_i        = r_i;
        n_b        = r_b;
        n_hit      = r_hit;
        n_min      = r_min;
        n_max      = r_max;
        n_sum      = r_sum;
        n_total    = r_total;
        n_out_vld  = r_out_vld;
        n_o_count  = r_o_count;
        n_o_bound  = r_o_bound;
        n_o_chosen = r_o_chosen;
        n_o_min    = r_o_min;
        n_o_max    = r_o_max;
        n_o_sum    = r_o_sum;
        n_o_total  = r_o_total;
        n_o_has    = r_o_has;
        o_pop      = 1'b0;
        rd_en      = 1'b0;
        mem_we     = 1'b0;
        clr        = 1'b0;
        if (r_out_vld && !i_stall) begin
            n_out_vld = 1'b0;
        end
        case (r_state)
            ebh_pkg::ST_IDLE: begin
                if (i_item_vld) begin
                    o_pop    = 1'b1;
                    n_op     = i_item.op;
                    n_sample = i_item.sample;
                    n_tgt    = item_tgt;
                    n_n      = used;
                    n_i      = '0;
                    n_b      = ebh_pkg::BOUND_W'(i_cfg.first_bound);
                    case (i_item.op)
                        ebh_pkg::OP_SUBMIT: begin
                            n_hit   = 1'b1;
                            n_state = ebh_pkg::ST_WALK;
                        end
                        ebh_pkg::OP_READ: begin
                            n_hit   = item_in;
                            n_state = item_in ? ebh_pkg::ST_WALK : ebh_pkg::ST_FIN;
                        end
                        default: begin
                            n_hit   = 1'b0;
                            n_state = ebh_pkg::ST_FIN;
                        end
                    endcase
                end
            end
            ebh_pkg::ST_WALK: begin
                if (walk_done) begin
                    n_state = ebh_pkg::ST_READ;
                end else begin
                    n_b = next_b;
                    n_i = i_inc;
                end
            end
            ebh_pkg::ST_READ: begin
                rd_en   = 1'b1;
                n_state = ebh_pkg::ST_FIN;
            end
            ebh_pkg::ST_FIN: begin
                if (out_free) begin
                    mem_we     = (r_op == ebh_pkg::OP_SUBMIT);
                    clr        = (r_op == ebh_pkg::OP_CLEAR);
                    n_min      = f_min;
                    n_max      = f_max;
                    n_sum      = f_sum;
                    n_total    = f_total;
                    n_out_vld  = 1'b1;
                    n_o_count  = ebh_pkg::COUNT_OUT_W'(f_cnt);
                    n_o_bound  = f_bnd;
                    n_o_chosen = f_chosen;
                    n_o_min    = f_has ? f_min : '0;
                    n_o_max    = f_has ? f_max : '0;
                    n_o_sum    = f_sum;
                    n_o_total  = ebh_pkg::COUNT_OUT_W'(f_total);
                    n_o_has    = f_has;
                    n_state    = ebh_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = ebh_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ebh_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min     <= SMASK;
            r_max     <= '0;
            r_sum     <= '0;
            r_total   <= '0;
            r_out_vld <= 1'b0;
            r_vld     <= '0;
        end else begin
            r_min     <= n_min;
            r_max     <= n_max;
            r_sum     <= n_sum;
            r_total   <= n_total;
            r_out_vld <= n_out_vld;
            if (clr) begin
                r_vld <= '0;
            end else if (mem_we) begin
                r_vld[addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_sample   <= n_sample;
        r_tgt      <= n_tgt;
        r_n        <= n_n;
        r_i        <= n_i;
        r_b        <= n_b;
        r_hit      <= n_hit;
        r_o_count  <= n_o_count;
        r_o_bound  <= n_o_bound;
        r_o_chosen <= n_o_chosen;
        r_o_min    <= n_o_min;
        r_o_max    <= n_o_max;
        r_o_sum    <= n_o_sum;
        r_o_total  <= n_o_total;
        r_o_has    <= n_o_has;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[addr] <= inc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= r_mem[addr];
            r_rd_vld  <= r_vld[addr];
        end
    end

    assign o_valid         = r_out_vld;
    assign o_bucket_count  = r_o_count;
    assign o_bucket_bound  = r_o_bound;
    assign o_chosen_bucket = r_o_chosen;
    assign o_min_sample    = r_o_min;
    assign o_max_sample    = r_o_max;
    assign o_sample_sum    = r_o_sum;
    assign o_sample_count  = r_o_total;
    assign o_has_samples   = r_o_has;

    `EBH_ASSERT_NOW(a_walk_in_range, i_clk, i_rst_n, r_state == ebh_pkg::ST_WALK, r_i < r_n, "walk index beyond buckets in use")
    `EBH_ASSERT_NEXT(a_fin_waits, i_clk, i_rst_n, (r_state == ebh_pkg::ST_FIN) && r_out_vld && i_stall, r_state == ebh_pkg::ST_FIN, "result finished while output register busy")
    `EBH_ASSERT_NOW(a_empty_stats, i_clk, i_rst_n, r_total == '0, (r_max == '0) && (r_min == SMASK) && (r_sum == '0), "statistics set without samples")

endmodule

// File: hdl/exponential_bucket_histogram.sv
// a request is popped from the queue, walks the bound table through one 48x16 multiplier
//   (submit: up to the hit, at most buckets in use; read: up to the index), reads the
//   bucket memory and finishes into the output register; clear, unknown requests and
//   reads beyond buckets in use skip walk and read; each item is finished before the next
// reset: synchronous active low; empties the queue, clears counts and statistics,
//   config returns to first bound 1, growth 2.0, 64 buckets
module exponential_bucket_histogram #(
    parameter int NUM_BUCKETS = 64,
    parameter int SAMPLE_BITS = 32,
    parameter int COUNT_BITS  = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // configuration write port
    input  logic                             i_cfg_we,
    input  logic [ebh_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [ebh_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    // request channel
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic [ebh_pkg::REQ_W-1:0]        i_req_type,
    input  logic [ebh_pkg::SAMPLE_W-1:0]     i_sample,
    input  logic [ebh_pkg::IDX_OUT_W-1:0]    i_bucket_index,
    // result channel
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic [ebh_pkg::COUNT_OUT_W-1:0]  o_bucket_count,
    output logic [ebh_pkg::BOUND_W-1:0]      o_bucket_bound,
    output logic [ebh_pkg::IDX_OUT_W-1:0]    o_chosen_bucket,
    output logic [ebh_pkg::SAMPLE_W-1:0]     o_min_sample,
    output logic [ebh_pkg::SAMPLE_W-1:0]     o_max_sample,
    output logic [ebh_pkg::SUM_W-1:0]        o_sample_sum,
    output logic [ebh_pkg::COUNT_OUT_W-1:0]  o_sample_count,
    output logic                             o_has_samples
);

    // configuration registers, written only while the block is idle; user must ensure
    ebh_pkg::t_cfg  r_cfg;

    // front to back: one classified request at the head of the queue
    logic           item_vld;
    ebh_pkg::t_item item;
    logic           pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.first_bound <= ebh_pkg::RST_FIRST_BOUND;
            r_cfg.growth      <= ebh_pkg::RST_GROWTH;
            r_cfg.buckets     <= ebh_pkg::RST_BUCKETS;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                ebh_pkg::CFG_FIRST_BOUND: r_cfg.first_bound <= i_cfg_wdata;
                ebh_pkg::CFG_GROWTH:      r_cfg.growth <= i_cfg_wdata[ebh_pkg::GROWTH_W-1:0];
                ebh_pkg::CFG_BUCKETS:     r_cfg.buckets <= i_cfg_wdata[ebh_pkg::USE_W-1:0];
                default: begin
                    // unmapped index, write ignored
                end
            endcase
        end
    end

    // front: takes each transfer, decodes the request and queues it
    ebh_front #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_req_type     (i_req_type),
        .i_sample       (i_sample),
        .i_bucket_index (i_bucket_index),
        .o_item_vld     (item_vld),
        .o_item         (item),
        .i_pop          (pop)
    );

    // back: bound walk, bucket memory update, statistics and output register
    ebh_back #(
        .NUM_BUCKETS (NUM_BUCKETS),
        .SAMPLE_BITS (SAMPLE_BITS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (r_cfg),
        .i_item_vld      (item_vld),
        .i_item          (item),
        .o_pop           (pop),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_bucket_count  (o_bucket_count),
        .o_bucket_bound  (o_bucket_bound),
        .o_chosen_bucket (o_chosen_bucket),
        .o_min_sample    (o_min_sample),
        .o_max_sample    (o_max_sample),
        .o_sample_sum    (o_sample_sum),
        .o_sample_count  (o_sample_count),
        .o_has_samples   (o_has_samples)
    );

endmodule

// File: tb/exponential_bucket_histogram_tb.sv
`timescale 1ns / 100ps

module exponential_bucket_histogram_tb;

    localparam int NUM_BUCKETS  = 64;
    localparam int PHASE_ITEMS  = 165;   // random requests per register setting
    localparam int LONG_HOLD    = 400;   // cycles the result side refuses transfers

    // one result transfer, field for field
    typedef struct packed {
        logic [ebh_pkg::COUNT_OUT_W-1:0] cnt;
        logic [ebh_pkg::BOUND_W-1:0]     bnd;
        logic [ebh_pkg::IDX_OUT_W-1:0]   chosen;
        logic [ebh_pkg::SAMPLE_W-1:0]    min_smp;
        logic [ebh_pkg::SAMPLE_W-1:0]    max_smp;
        logic [ebh_pkg::SUM_W-1:0]       sum;
        logic [ebh_pkg::COUNT_OUT_W-1:0] total;
        logic                            has;
    } t_hist_report;

    // receiver stall patterns
    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HALF,
        STALL_HEAVY
    } t_stall_mode;

    // histogram predictor plus the queue of reports it still owes
    class t_hist_scoreboard;
        logic [ebh_pkg::FIRST_W-1:0]     first_bound;
        logic [ebh_pkg::GROWTH_W-1:0]    growth;
        logic [ebh_pkg::USE_W-1:0]       buckets;
        logic [ebh_pkg::COUNT_OUT_W-1:0] counts[NUM_BUCKETS];
        logic [ebh_pkg::SAMPLE_W-1:0]    min_seen;
        logic [ebh_pkg::SAMPLE_W-1:0]    max_seen;
        logic [ebh_pkg::SUM_W-1:0]       running_sum;
        logic [ebh_pkg::COUNT_OUT_W-1:0] total;
        t_hist_report                    expected_reports[$];
        int                              errors;

        function new();
            first_bound = ebh_pkg::RST_FIRST_BOUND;
            growth      = ebh_pkg::RST_GROWTH;
            buckets     = ebh_pkg::RST_BUCKETS;
            errors      = 0;
            clear_stats();
        endfunction

        function void clear_stats();
            foreach (counts[i]) counts[i] = '0;
            min_seen    = '1;
            max_seen    = '0;
            running_sum = '0;
            total       = '0;
        endfunction

        function void write_reg(logic [ebh_pkg::CFG_IDX_W-1:0] idx,
                                logic [ebh_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                ebh_pkg::CFG_FIRST_BOUND: first_bound = data[ebh_pkg::FIRST_W-1:0];
                ebh_pkg::CFG_GROWTH:      growth      = data[ebh_pkg::GROWTH_W-1:0];
                ebh_pkg::CFG_BUCKETS:     buckets     = data[ebh_pkg::USE_W-1:0];
                default: ;
            endcase
        endfunction

        // zero acts as one, anything past the array acts as the full array
        function int used_buckets();
            if (buckets == 0) return 1;
            if (buckets > NUM_BUCKETS) return NUM_BUCKETS;
            return int'(buckets);
        endfunction

        // truncated Q8.8 product, saturated to the bound width
        function logic [ebh_pkg::BOUND_W-1:0] next_bound(logic [ebh_pkg::BOUND_W-1:0] b);
            logic [63:0] p;
            p = ({16'd0, b} * {48'd0, growth}) >> ebh_pkg::FRAC_BITS;
            return (p > {16'd0, ebh_pkg::BOUND_MAX}) ? ebh_pkg::BOUND_MAX
                                                     : p[ebh_pkg::BOUND_W-1:0];
        endfunction

        function logic [ebh_pkg::BOUND_W-1:0] bound_at(int k);
            logic [ebh_pkg::BOUND_W-1:0] b;
            b = {16'd0, first_bound};
            for (int i = 0; i < k; i++) b = next_bound(b);
            return b;
        endfunction

        // accepted request: update the histogram and queue the report it owes
        function void log_request(ebh_pkg::t_op op, logic [ebh_pkg::SAMPLE_W-1:0] smp,
                                  logic [ebh_pkg::IDX_OUT_W-1:0] idx);
            t_hist_report                r;
            int                          n;
            int                          k;
            bit                          hit;
            logic [ebh_pkg::BOUND_W-1:0] b;
            n = used_buckets();
            r = '0;
            case (op)
                ebh_pkg::OP_SUBMIT: begin
                    // first bound strictly above the sample, else the last bucket in use
                    b   = {16'd0, first_bound};
                    k   = n - 1;
                    hit = 1'b0;
                    for (int i = 0; i < n && !hit; i++) begin
                        if ({16'd0, smp} < b) begin
                            k   = i;
                            hit = 1'b1;
                        end else if (i + 1 < n) begin
                            b = next_bound(b);
                        end
                    end
                    if (counts[k] != '1) counts[k] = counts[k] + 1'b1;
                    if (total != '1) total = total + 1'b1;
                    running_sum = running_sum + {32'd0, smp};
                    if (smp < min_seen) min_seen = smp;
                    if (smp > max_seen) max_seen = smp;
                    r.cnt    = counts[k];
                    r.bnd    = b;
                    r.chosen = 6'(k);
                end
                ebh_pkg::OP_CLEAR: clear_stats();
                ebh_pkg::OP_READ: begin
                    // reads past the buckets in use report zeros
                    if (int'(idx) < n) begin
                        r.cnt = counts[idx];
                        r.bnd = bound_at(int'(idx));
                    end
                end
                default: ;
            endcase
            r.min_smp = (total != 0) ? min_seen : '0;
            r.max_smp = (total != 0) ? max_seen : '0;
            r.sum     = running_sum;
            r.total   = total;
            r.has     = (total != 0);
            expected_reports.insert(expected_reports.size(), r);
        endfunction

        function void check_field(string name, logic [63:0] want, logic [63:0] got);
            if (got !== want) begin
                errors++;
                $display("%0t: %s mismatch, expected %0h, got %0h",
                         $time, name, want, got);
            end
        endfunction

        function void compare_report(t_hist_report got);
            t_hist_report want;
            if (expected_reports.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, got %h", $time, got);
                return;
            end
            want = expected_reports.pop_front();
            check_field("bucket_count",  64'(want.cnt),     64'(got.cnt));
            check_field("bucket_bound",  64'(want.bnd),     64'(got.bnd));
            check_field("chosen_bucket", 64'(want.chosen),  64'(got.chosen));
            check_field("min_sample",    64'(want.min_smp), 64'(got.min_smp));
            check_field("max_sample",    64'(want.max_smp), 64'(got.max_smp));
            check_field("sample_sum",    want.sum,          got.sum);
            check_field("sample_count",  64'(want.total),   64'(got.total));
            check_field("has_samples",   64'(want.has),     64'(got.has));
        endfunction
    endclass

    // clock, reset and block ports, the driven inputs known from time zero
    logic                            i_clk;
    logic                            i_rst_n        = 1'b0;
    logic                            i_cfg_we       = 1'b0;
    logic [ebh_pkg::CFG_IDX_W-1:0]   i_cfg_idx      = '0;
    logic [ebh_pkg::CFG_DATA_W-1:0]  i_cfg_wdata    = '0;
    logic                            i_valid        = 1'b0;
    logic                            o_stall;
    logic [ebh_pkg::REQ_W-1:0]       i_req_type     = '0;
    logic [ebh_pkg::SAMPLE_W-1:0]    i_sample       = '0;
    logic [ebh_pkg::IDX_OUT_W-1:0]   i_bucket_index = '0;
    logic                            o_valid;
    logic                            i_stall        = 1'b0;
    logic [ebh_pkg::COUNT_OUT_W-1:0] o_bucket_count;
    logic [ebh_pkg::BOUND_W-1:0]     o_bucket_bound;
    logic [ebh_pkg::IDX_OUT_W-1:0]   o_chosen_bucket;
    logic [ebh_pkg::SAMPLE_W-1:0]    o_min_sample;
    logic [ebh_pkg::SAMPLE_W-1:0]    o_max_sample;
    logic [ebh_pkg::SUM_W-1:0]       o_sample_sum;
    logic [ebh_pkg::COUNT_OUT_W-1:0] o_sample_count;
    logic                            o_has_samples;

    t_hist_scoreboard sb;
    bit               hold_request = 1'b0;   // asks the result side for one long hold-off

    exponential_bucket_histogram DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_req_type     (i_req_type),
        .i_sample       (i_sample),
        .i_bucket_index (i_bucket_index),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_bucket_count (o_bucket_count),
        .o_bucket_bound (o_bucket_bound),
        .o_chosen_bucket(o_chosen_bucket),
        .o_min_sample   (o_min_sample),
        .o_max_sample   (o_max_sample),
        .o_sample_sum   (o_sample_sum),
        .o_sample_count (o_sample_count),
        .o_has_samples  (o_has_samples)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // watchdog, far above the slowest legal run
    initial begin
        #3_000_000;
        $display("exponential_bucket_histogram test failed");
        $finish;
    end

    // offer one request and hold it until the transfer happens
    task automatic send_req(ebh_pkg::t_op op, logic [ebh_pkg::SAMPLE_W-1:0] smp,
                            logic [ebh_pkg::IDX_OUT_W-1:0] idx);
        i_valid        <= 1'b1;
        i_req_type     <= op;
        i_sample       <= smp;
        i_bucket_index <= idx;
        do @(posedge i_clk); while (o_stall);
        sb.log_request(op, smp, idx);
    endtask

    // sender gap; valid only drops if it is still up
    task automatic pause_sender(int cycles);
        if (i_valid) i_valid <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    // stop offering and wait for every owed report, then let the block settle
    task automatic drain();
        if (i_valid) i_valid <= 1'b0;
        do @(posedge i_clk); while (sb.expected_reports.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    // all three registers, one per clock, only while idle
    task automatic program_regs(logic [ebh_pkg::FIRST_W-1:0] fb,
                                logic [ebh_pkg::GROWTH_W-1:0] g,
                                logic [ebh_pkg::USE_W-1:0] n);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= ebh_pkg::CFG_FIRST_BOUND;
        i_cfg_wdata <= fb;
        @(posedge i_clk);
        sb.write_reg(ebh_pkg::CFG_FIRST_BOUND, fb);
        i_cfg_idx   <= ebh_pkg::CFG_GROWTH;
        i_cfg_wdata <= {16'd0, g};
        @(posedge i_clk);
        sb.write_reg(ebh_pkg::CFG_GROWTH, {16'd0, g});
        i_cfg_idx   <= ebh_pkg::CFG_BUCKETS;
        i_cfg_wdata <= {25'd0, n};
        @(posedge i_clk);
        sb.write_reg(ebh_pkg::CFG_BUCKETS, {25'd0, n});
        i_cfg_we    <= 1'b0;
    endtask

    // samples lean toward bucket edges, where off-by-one errors live
    function automatic logic [ebh_pkg::SAMPLE_W-1:0] pick_sample();
        logic [ebh_pkg::BOUND_W-1:0] b;
        case ($urandom_range(0, 9))
            0, 1, 2: return $urandom;
            3, 4:    return $urandom_range(0, 15);
            5, 6, 7: begin
                b = sb.bound_at($urandom_range(0, sb.used_buckets() - 1));
                b = b - 1'b1 + $urandom_range(0, 2);
                return (b[ebh_pkg::BOUND_W-1:ebh_pkg::SAMPLE_W] == 0) ?
                       b[ebh_pkg::SAMPLE_W-1:0] : $urandom;
            end
            8:       return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
            default: return $urandom >> $urandom_range(0, 31);
        endcase
    endfunction

    // mostly submits and reads, occasional clear and unused request code
    task automatic random_item();
        int unsigned r;
        int          idx;
        r   = $urandom_range(0, 99);
        idx = ($urandom_range(0, 3) != 0) ? $urandom_range(0, sb.used_buckets() - 1)
                                          : $urandom_range(0, NUM_BUCKETS - 1);
        if (r < 62)      send_req(ebh_pkg::OP_SUBMIT, pick_sample(), 6'($urandom));
        else if (r < 92) send_req(ebh_pkg::OP_READ, $urandom, 6'(idx));
        else if (r < 96) send_req(ebh_pkg::OP_CLEAR, $urandom, 6'($urandom));
        else             send_req(ebh_pkg::OP_NOP, $urandom, 6'($urandom));
    endtask

    // bursts of random length with random gaps, sometimes long runs back to back
    task automatic run_phase(int items);
        int sent;
        int burst;
        sent = 0;
        while (sent < items) begin
            burst = ($urandom_range(0, 4) == 0) ? 40 : $urandom_range(1, 12);
            repeat (burst) begin
                random_item();
                sent++;
            end
            if ($urandom_range(0, 2) != 0) pause_sender($urandom_range(1, 15));
        end
    endtask

    task automatic run_setting(logic [ebh_pkg::FIRST_W-1:0] fb,
                               logic [ebh_pkg::GROWTH_W-1:0] g,
                               logic [ebh_pkg::USE_W-1:0] n, bit long_hold, bit pause_midway);
        drain();
        program_regs(fb, g, n);
        if (long_hold) hold_request = 1'b1;
        if (pause_midway) begin
            // sender waits for every report before going on
            run_phase(PHASE_ITEMS / 2);
            drain();
            run_phase(PHASE_ITEMS / 2);
        end else begin
            run_phase(PHASE_ITEMS);
        end
    endtask

    // result side: check each transfer, then pick the next stall value
    initial begin : result_sink
        int          hold_left;
        int          stretch_left;
        t_stall_mode stall_mode;
        hold_left    = 0;
        stretch_left = 0;
        stall_mode   = STALL_NONE;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && !i_stall)
                sb.compare_report('{o_bucket_count, o_bucket_bound, o_chosen_bucket,
                                    o_min_sample, o_max_sample, o_sample_sum,
                                    o_sample_count, o_has_samples});
            if (hold_request) begin
                hold_left    = LONG_HOLD;
                hold_request = 1'b0;
            end
            if (hold_left > 0) begin
                // long hold-off so the block backs up and stalls its input
                hold_left--;
                i_stall <= 1'b1;
            end else begin
                if (stretch_left == 0) begin
                    stall_mode   = t_stall_mode'($urandom_range(0, 3));
                    stretch_left = $urandom_range(5, 60);
                end
                stretch_left--;
                case (stall_mode)
                    STALL_NONE:  i_stall <= 1'b0;
                    STALL_LIGHT: i_stall <= ($urandom_range(0, 3) == 0);
                    STALL_HALF:  i_stall <= $urandom_range(0, 1);
                    default:     i_stall <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    initial begin : stimulus
        sb = new();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: bounds 1, 2, 4, ... saturating past bucket 47
        send_req(ebh_pkg::OP_READ, 32'h0, 6'd0);              // empty: min and max read as zero
        send_req(ebh_pkg::OP_NOP, 32'hFFFF_FFFF, 6'h3F);      // unused code changes nothing
        send_req(ebh_pkg::OP_SUBMIT, 32'h0, 6'h3F);           // smallest sample
        send_req(ebh_pkg::OP_SUBMIT, 32'hFFFF_FFFF, 6'h0);    // largest sample
        send_req(ebh_pkg::OP_SUBMIT, 32'h1, 6'h0);            // exactly on bound zero
        send_req(ebh_pkg::OP_SUBMIT, 32'h2, 6'h0);
        send_req(ebh_pkg::OP_SUBMIT, 32'h3, 6'h0);
        send_req(ebh_pkg::OP_SUBMIT, 32'h7FFF_FFFF, 6'h0);
        send_req(ebh_pkg::OP_SUBMIT, 32'h8000_0000, 6'h0);
        send_req(ebh_pkg::OP_READ, 32'h0, 6'd63);             // saturated bound
        send_req(ebh_pkg::OP_READ, 32'h0, 6'd47);
        send_req(ebh_pkg::OP_READ, 32'h0, 6'd0);
        send_req(ebh_pkg::OP_READ, 32'h0, 6'd32);
        send_req(ebh_pkg::OP_READ, 32'hFFFF_FFFF, 6'd2);
        send_req(ebh_pkg::OP_CLEAR, 32'h0, 6'h0);
        send_req(ebh_pkg::OP_READ, 32'h0, 6'd32);             // count gone after clear
        send_req(ebh_pkg::OP_NOP, 32'h0, 6'h0);
        send_req(ebh_pkg::OP_SUBMIT, 32'h5, 6'h0);
        send_req(ebh_pkg::OP_SUBMIT, 32'hAAAA_5555, 6'h2A);
        send_req(ebh_pkg::OP_SUBMIT, 32'h5555_AAAA, 6'h15);

        // register sweep: extremes first, then random settings
        run_setting(32'd1, 16'd65535, 7'd1, 1'b1, 1'b0);          // one bucket, long hold
        run_setting(32'hFFFF_FFFF, 16'd65535, 7'd64, 1'b0, 1'b0); // bounds saturate from bucket 3 on
        run_setting(32'd1, 16'd257, 7'd64, 1'b0, 1'b0);           // slowest growth, longest walk
        run_setting(32'd1000, 16'd384, 7'd0, 1'b0, 1'b0);         // zero buckets acts as one
        run_setting(32'd7, 16'd300, 7'd127, 1'b0, 1'b1);          // above array acts as full
        run_setting(32'd100, 16'd256, 7'd20, 1'b0, 1'b0);         // growth of exactly one
        run_setting(32'd50, 16'd0, 7'd10, 1'b0, 1'b0);            // growth of zero
        run_setting(32'd3, 16'd65535, 7'd64, 1'b0, 1'b0);
        repeat (3)
            run_setting(($urandom >> $urandom_range(0, 31)) | 32'd1,
                        $urandom_range(0, 1) ? $urandom_range(257, 1024)
                                             : $urandom_range(257, 65535),
                        $urandom_range(1, 64), 1'b0, 1'b0);
        run_setting(ebh_pkg::RST_FIRST_BOUND, ebh_pkg::RST_GROWTH, ebh_pkg::RST_BUCKETS,
                    1'b0, 1'b0);

        drain();
        repeat (30) @(posedge i_clk);
        if (sb.errors == 0 && sb.expected_reports.size() == 0) begin
            $display("exponential_bucket_histogram test passed");
        end else begin
            $display("exponential_bucket_histogram test failed");
        end
        $finish;
    end

endmodule
